// ----- design/cmv_pkg.sv -----
// cmv_pkg: types, constants and arithmetic helpers of the complex matrix-vector unit
// no dependencies; used by the interfaces and every module of the unit
`default_nettype none

package cmv_pkg;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } cfg_reg_e;

  localparam logic [6:0] ROW_COUNT_RST = 7'd16;
  localparam logic [5:0] COL_COUNT_RST = 6'd16;

  // saturation limits of the 32-bit accumulators
  localparam logic signed [31:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ACC_MIN = 32'sh8000_0000;

  // input word: one matrix element and the vector element of its column
  typedef struct packed {
    logic signed [15:0] mat_re;
    logic signed [15:0] mat_im;
    logic signed [15:0] vec_re;
    logic signed [15:0] vec_im;
  } item_t;

  // result word: one finished row of the product vector
  typedef struct packed {
    logic [5:0]         row_index;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               last_row;
  } res_t;

  // position flags of one element inside the frame
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic last_row;
  } flags_t;

  // the four partial products of one complex multiply
  typedef struct packed {
    logic signed [31:0] re_re;   // a.re * v.re
    logic signed [31:0] im_nim;  // a.im * (-v.im)
    logic signed [31:0] re_im;   // a.re * v.im
    logic signed [31:0] im_re;   // a.im * v.re
  } prod_t;

  // one accumulator pair
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } acc_t;

  // exact sum of two products
  function automatic logic signed [32:0] pair_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    pair_sum = {a[31], a} + {b[31], b};
  endfunction

  // accumulator plus pair sum, clipped to signed 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [32:0] inc);
    logic [33:0] s;
    s = {{2{acc[31]}}, acc} + {inc[32], inc};
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      sat_add = s[31:0];
    end else if (s[33]) begin
      sat_add = ACC_MIN;
    end else begin
      sat_add = ACC_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/cmv_intf.sv -----
// cmv_intf: valid/ready channel interfaces of the complex matrix-vector unit
// depends on cmv_pkg for the word types
`default_nettype none

// matrix/vector element channel
interface cmv_item_if;
  logic           valid;
  logic           ready;
  cmv_pkg::item_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// result channel
interface cmv_res_if;
  logic          valid;
  logic          ready;
  cmv_pkg::res_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// configuration write channel
interface cmv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cmv_pkg::CFG_IDX_W-1:0]       index;
  logic [cmv_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/complex_int16_matvec_unit.sv -----
// complex_int16_matvec_unit: streaming complex int16 matrix-vector product, top level
// depends on cmv_pkg, cmv_intf, cmv_seq, cmv_cmul and cmv_acc_mem
//
//   channel   dir  word                                      handshake
//   item_i    in   mat_re, mat_im, vec_re, vec_im            valid/ready
//   result_o  out  row_index, res_re, res_im, last_row       valid/ready
//   cfg_i     in   index (0 row_count, 1 col_count), data    valid/ready, always ready
//
// One element is taken per cycle. From acceptance, a result word passes the input
// register, the product register, then the accumulate into the accumulator store
// and the result register. A row's result appears on its last column. Reset clears
// the counters and the pipeline valids; the accumulator store has no reset. Input
// stalls only when an element of the last column reaches the accumulate stage while
// the result register is full and result_o.ready is low.
`default_nettype none

module complex_int16_matvec_unit #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cmv_item_if.sink    item_i,
  cmv_res_if.source   result_o,
  cmv_cfg_if.sink     cfg_i
);
  import cmv_pkg::*;

  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic             advance;
  logic             accept;
  logic [ROW_W-1:0] pos_row;
  flags_t           pos_flags;

  logic             s1_valid_q;
  item_t            s1_item_q;
  logic [ROW_W-1:0] s1_row_q;
  flags_t           s1_flags_q;

  logic             s2_valid_q;
  logic [ROW_W-1:0] s2_row_q;
  flags_t           s2_flags_q;
  prod_t            s2_prod;
  logic             byp_q;
  acc_t             byp_data_q;
  acc_t             rd_data;
  acc_t             acc_old;
  acc_t             acc_new;
  logic signed [32:0] sum_re;
  logic signed [32:0] sum_im;

  logic             res_valid_q;
  res_t             res_q;

  // whole pipeline moves unless a result is blocked by a full output register
  assign advance = !s2_valid_q || !s2_flags_q.last_col || !res_valid_q || result_o.ready;
  assign accept  = item_i.valid && advance;
  assign item_i.ready = advance;

  // frame position and configuration
  cmv_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .accept_i (accept),
    .row_o    (pos_row),
    .flags_o  (pos_flags)
  );

  // input stage and accumulate stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= item_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  // input stage and accumulate stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_item_q  <= item_i.word;
      s1_row_q   <= pos_row;
      s1_flags_q <= pos_flags;
      s2_row_q   <= s1_row_q;
      s2_flags_q <= s1_flags_q;
      // the element now in the accumulate stage writes the row being read
      byp_q      <= s2_valid_q && (s2_row_q == s1_row_q);
      byp_data_q <= acc_new;
    end
  end

  // complex multiply, products registered alongside the store read
  cmv_cmul u_cmul (
    .clk_i  (clk_i),
    .en_i   (advance),
    .op_i   (s1_item_q),
    .prod_o (s2_prod)
  );

  cmv_acc_mem #(
    .DEPTH  (MAX_ROWS),
    .ADDR_W (ROW_W)
  ) u_acc_mem (
    .clk_i     (clk_i),
    .rd_en_i   (advance),
    .rd_addr_i (s1_row_q),
    .rd_data_o (rd_data),
    .wr_en_i   (advance && s2_valid_q),
    .wr_addr_i (s2_row_q),
    .wr_data_i (acc_new)
  );

  // accumulate: wrapped set on the first column, saturating add afterwards
  always_comb begin
    acc_old = byp_q ? byp_data_q : rd_data;
    sum_re  = pair_sum(s2_prod.re_re, s2_prod.im_nim);
    sum_im  = pair_sum(s2_prod.re_im, s2_prod.im_re);
    if (s2_flags_q.first_col) begin
      acc_new.re = sum_re[31:0];
      acc_new.im = sum_im[31:0];
    end else begin
      acc_new.re = sat_add(acc_old.re, sum_re);
      acc_new.im = sat_add(acc_old.im, sum_im);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && s2_valid_q && s2_flags_q.last_col) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q && s2_flags_q.last_col) begin
      res_q.row_index <= 6'(s2_row_q);
      res_q.res_re    <= acc_new.re[15:0];
      res_q.res_im    <= acc_new.im[15:0];
      res_q.last_row  <= s2_flags_q.last_row;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.word  = res_q;

`ifndef NO_ASSERTIONS
  // a blocked result word holds back the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_flags_q.last_col && res_valid_q && !result_o.ready)
      |-> !item_i.ready)
    else $error("input accepted while a result word is blocked");

  // back-to-back elements share a row only with a single-row frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && (s1_row_q == s2_row_q)) |-> s2_flags_q.last_row)
    else $error("consecutive elements on the same row in a multi-row frame");

  // a result word only follows a last-column element leaving the accumulate stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(advance && s2_valid_q && s2_flags_q.last_col))
    else $error("result word without a last-column element");
`endif

endmodule

`default_nettype wire

// ----- design/cmv_seq.sv -----
// cmv_seq: configuration registers and row/column position counters
// depends on cmv_pkg and cmv_intf
`default_nettype none

module cmv_seq #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned ROW_W    = 6,
  parameter int unsigned COL_W    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  cmv_cfg_if.sink               cfg_i,
  input  wire logic             accept_i,
  output logic [ROW_W-1:0]      row_o,
  output cmv_pkg::flags_t       flags_o
);
  import cmv_pkg::*;

  localparam int unsigned RCNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS + 1) : 1;
  localparam int unsigned CCNT_W = (MAX_COLS > 1) ? $clog2(MAX_COLS + 1) : 1;

  logic [6:0]        row_count_q;
  logic [5:0]        col_count_q;
  logic [ROW_W-1:0]  row_pos_q;
  logic [COL_W-1:0]  col_pos_q;
  logic [RCNT_W-1:0] rows_eff;
  logic [CCNT_W-1:0] cols_eff;
  logic [RCNT_W-1:0] row_inc;
  logic [CCNT_W-1:0] col_inc;
  logic              cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  // clamp the configured counts into 1..MAX
  always_comb begin
    if (row_count_q == 7'd0) begin
      rows_eff = RCNT_W'(1);
    end else if ({2'b00, row_count_q} > 9'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(row_count_q);
    end
    if (col_count_q == 6'd0) begin
      cols_eff = CCNT_W'(1);
    end else if ({3'b000, col_count_q} > 9'(MAX_COLS)) begin
      cols_eff = CCNT_W'(MAX_COLS);
    end else begin
      cols_eff = CCNT_W'(col_count_q);
    end
  end

  // position flags of the next element
  assign row_inc           = RCNT_W'(row_pos_q) + RCNT_W'(1);
  assign col_inc           = CCNT_W'(col_pos_q) + CCNT_W'(1);
  assign row_o             = row_pos_q;
  assign flags_o.first_col = (col_pos_q == '0);
  assign flags_o.last_col  = (col_inc == cols_eff);
  assign flags_o.last_row  = (row_inc == rows_eff);

  // config registers; a write to a mapped register restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        REG_ROW_COUNT: begin
          row_count_q <= cfg_i.data;
          row_pos_q   <= '0;
          col_pos_q   <= '0;
        end
        REG_COL_COUNT: begin
          col_count_q <= cfg_i.data[5:0];
          row_pos_q   <= '0;
          col_pos_q   <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept_i) begin
      // column-major walk: rows first, then the next column
      if (flags_o.last_row) begin
        row_pos_q <= '0;
        if (flags_o.last_col) begin
          col_pos_q <= '0;
        end else begin
          col_pos_q <= col_pos_q + COL_W'(1);
        end
      end else begin
        row_pos_q <= row_pos_q + ROW_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/cmv_cmul.sv -----
// cmv_cmul: registered partial products of one complex int16 multiply
// depends on cmv_pkg
`default_nettype none

module cmv_cmul (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire cmv_pkg::item_t  op_i,
  output cmv_pkg::prod_t       prod_o
);
  import cmv_pkg::*;

  logic signed [15:0] nvim;
  prod_t              prod_d;
  prod_t              prod_q;

  // negated vector imaginary part, wrapping in 16 bits
  assign nvim = ~op_i.vec_im + 16'sd1;

  // four 16x16 signed products
  always_comb begin
    prod_d.re_re  = op_i.mat_re * op_i.vec_re;
    prod_d.im_nim = op_i.mat_im * nvim;
    prod_d.re_im  = op_i.mat_re * op_i.vec_im;
    prod_d.im_re  = op_i.mat_im * op_i.vec_re;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- design/cmv_acc_mem.sv -----
// cmv_acc_mem: accumulator store, one write and one registered read per cycle
// depends on cmv_pkg
`default_nettype none

module cmv_acc_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rd_en_i,
  input  wire logic [ADDR_W-1:0]  rd_addr_i,
  output cmv_pkg::acc_t           rd_data_o,
  input  wire logic               wr_en_i,
  input  wire logic [ADDR_W-1:0]  wr_addr_i,
  input  wire cmv_pkg::acc_t      wr_data_i
);
  import cmv_pkg::*;

  acc_t mem [DEPTH];
  acc_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sim/complex_int16_matvec_unit_tb.sv -----
// complex_int16_matvec_unit_tb: self-checking bench for the complex matrix-vector unit
// predicts every result word from the accepted element words and compares field by field
// depends on cmv_pkg, cmv_intf and complex_int16_matvec_unit
`timescale 1ns / 100ps

module complex_int16_matvec_unit_tb;
  import cmv_pkg::*;

  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLS    = 32;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ITEMS = 32;

  // unmapped register indexes, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [15:0] S_MIN = 16'h8000;
  localparam logic [15:0] S_MAX = 16'h7FFF;

  logic clk;
  logic rst_n;

  cmv_item_if item_bus ();
  cmv_res_if  res_bus ();
  cmv_cfg_if  cfg_bus ();

  complex_int16_matvec_unit #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(res_bus),
    .cfg_i   (cfg_bus)
  );

  // bench-side copy of the unit state
  int          row_acc_re [MAX_ROWS];
  int          row_acc_im [MAX_ROWS];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  logic [6:0]  row_cnt = ROW_COUNT_RST;
  logic [5:0]  col_cnt = COL_COUNT_RST;

  res_t        pending_rows [$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  // idling knobs, set only at the falling edge; hold_left counts down at the rising edge
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("complex_int16_matvec_unit: mismatch");
      $finish;
    end
  end

  function automatic int unsigned rows_in_use();
    if (row_cnt == 0) return 1;
    if (row_cnt > MAX_ROWS) return MAX_ROWS;
    return row_cnt;
  endfunction

  function automatic int unsigned cols_in_use();
    if (col_cnt == 0) return 1;
    if (col_cnt > MAX_COLS) return MAX_COLS;
    return col_cnt;
  endfunction

  // signed 32-bit clip of an exact sum
  function automatic int clip32(input longint s);
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return int'(s);
  endfunction

  // complex multiply-accumulate of one element word, queues the row word on the last column
  function automatic void accumulate_element(input item_t w);
    shortint     are, aim, vre, vim, nvim;
    int          p_rr, p_in, p_ri, p_ir;
    int unsigned nr, nc;
    res_t        row_word;
    nr   = rows_in_use();
    nc   = cols_in_use();
    are  = w.mat_re;
    aim  = w.mat_im;
    vre  = w.vec_re;
    vim  = w.vec_im;
    nvim = -vim;
    p_rr = are * vre;
    p_in = aim * nvim;
    p_ri = are * vim;
    p_ir = aim * vre;
    if (row_pos >= nr) row_pos = 0;
    if (col_pos >= nc) col_pos = 0;
    // first column wraps, later columns saturate
    if (col_pos == 0) begin
      row_acc_re[row_pos] = p_rr + p_in;
      row_acc_im[row_pos] = p_ri + p_ir;
    end else begin
      row_acc_re[row_pos] = clip32(longint'(row_acc_re[row_pos]) + p_rr + p_in);
      row_acc_im[row_pos] = clip32(longint'(row_acc_im[row_pos]) + p_ri + p_ir);
    end
    if (col_pos + 1 == nc) begin
      row_word.row_index = 6'(row_pos);
      row_word.res_re    = row_acc_re[row_pos][15:0];
      row_word.res_im    = row_acc_im[row_pos][15:0];
      row_word.last_row  = (row_pos + 1 == nr);
      pending_rows.push_back(row_word);
    end
    // step through the frame in column-major order
    row_pos++;
    if (row_pos >= nr) begin
      row_pos = 0;
      col_pos++;
      if (col_pos >= nc) col_pos = 0;
    end
  endfunction

  task automatic report_field(input string field, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    error_count++;
    $display("%0t ns: %s expected %h actual %h", $time, field, want_v, got_v);
  endtask

  // result side: check each accepted word, then decide ready for the next edge
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got = res_bus.word;
      if (pending_rows.size() == 0) begin
        error_count++;
        $display("%0t ns: result word with nothing expected, expected none actual %h",
                 $time, got);
      end else begin
        want = pending_rows.pop_front();
        if (got.row_index !== want.row_index)
          report_field("row_index", 16'(want.row_index), 16'(got.row_index));
        if (got.res_re !== want.res_re) report_field("res_re", want.res_re, got.res_re);
        if (got.res_im !== want.res_im) report_field("res_im", want.res_im, got.res_im);
        if (got.last_row !== want.last_row)
          report_field("last_row", 16'(want.last_row), 16'(got.last_row));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // send one element word, with random idle cycles ahead of it
  task automatic send_element(input item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.word  <= w;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    items_sent++;
    accumulate_element(w);
  endtask

  task automatic send_parts(input logic [15:0] a_re, a_im, v_re, v_im);
    item_t w;
    w.mat_re = a_re;
    w.mat_im = a_im;
    w.vec_re = v_re;
    w.vec_im = v_im;
    send_element(w);
  endtask

  // stop offering and wait until every expected word is back and the pipe is empty
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write while the unit is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_ROW_COUNT) begin
      row_cnt = value;
    end else if (idx == REG_COL_COUNT) begin
      col_cnt = value[5:0];
    end
    if (idx == REG_ROW_COUNT || idx == REG_COL_COUNT) begin
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    item_bus.valid <= 1'b0;
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    @(posedge clk);
  endtask

  // operand values biased towards the extremes
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return 16'($urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  // column-major element words, one vector element per column, a little noise
  task automatic send_frame(input int unsigned n_rows, input int unsigned n_items);
    item_t       w;
    int unsigned k;
    logic [15:0] vr;
    logic [15:0] vi;
    vr = pick_value();
    vi = pick_value();
    for (k = 0; k < n_items; k++) begin
      if (k % n_rows == 0 || $urandom_range(19) == 0) begin
        vr = pick_value();
        vi = pick_value();
      end
      w.mat_re = pick_value();
      w.mat_im = pick_value();
      w.vec_re = vr;
      w.vec_im = vi;
      send_element(w);
    end
  endtask

  // reset sizes straight after reset
  task automatic test_reset_size();
    send_frame(rows_in_use(), rows_in_use() * cols_in_use());
  endtask

  // one column: wrapped first sums come out directly
  task automatic test_single_column();
    write_reg(REG_ROW_COUNT, 7'd1);
    write_reg(REG_COL_COUNT, 7'd1);
    send_parts(S_MIN, S_MIN, S_MIN, S_MIN);
    send_parts(S_MAX, S_MAX, S_MAX, S_MAX);
    send_parts(S_MIN, S_MAX, S_MIN, S_MAX);
    send_parts(S_MAX, S_MIN, S_MAX, S_MIN);
    send_parts(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_parts(16'hFFFF, 16'hFFFF, 16'hFFFF, S_MIN);
    write_reg(REG_ROW_COUNT, 7'd3);
    send_parts(S_MIN, S_MIN, S_MAX, S_MIN);
    send_parts(16'h0001, S_MAX, S_MIN, 16'hFFFF);
    send_parts(S_MAX, 16'h0001, 16'h0001, S_MAX);
  endtask

  // later columns clip at both ends, first column wraps
  task automatic test_saturation();
    write_reg(REG_ROW_COUNT, 7'd1);
    write_reg(REG_COL_COUNT, 7'd3);
    repeat (3) send_parts(S_MIN, S_MIN, S_MIN, S_MAX);
    repeat (3) send_parts(S_MIN, S_MAX, S_MAX, S_MAX);
    write_reg(REG_COL_COUNT, 7'd2);
    repeat (2) send_parts(S_MIN, S_MIN, S_MIN, S_MIN);
  endtask

  // zero counts act as one, col_count keeps six bits
  task automatic test_count_clamping();
    write_reg(REG_ROW_COUNT, 7'd0);
    write_reg(REG_COL_COUNT, 7'd0);
    send_parts(S_MAX, S_MIN, 16'h1234, 16'hEDCB);
    send_parts(16'h0001, 16'hFFFF, S_MAX, S_MIN);
    write_reg(REG_COL_COUNT, 7'h41);
    send_parts(S_MIN, S_MAX, 16'h5555, 16'hAAAA);
  endtask

  // writes to unmapped indexes do not restart the frame
  task automatic test_unmapped_write();
    write_reg(REG_ROW_COUNT, 7'd2);
    write_reg(REG_COL_COUNT, 7'd2);
    send_parts(16'h4000, 16'hC000, 16'h7FFF, 16'h0003);
    write_reg(REG_SPARE_2, 7'h55);
    write_reg(REG_SPARE_3, 7'h2A);
    send_parts(16'hC000, 16'h4000, 16'h7FFF, 16'h0003);
    send_parts(S_MAX, S_MIN, 16'h8001, 16'hFFFE);
    send_parts(S_MIN, S_MAX, 16'h8001, 16'hFFFE);
  endtask

  // long result hold-off fills the unit, then the sender waits for a full drain
  task automatic test_backpressure();
    write_reg(REG_ROW_COUNT, 7'd127);
    write_reg(REG_COL_COUNT, 7'd1);
    item_bus.valid <= 1'b0;
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    send_frame(rows_in_use(), 32);
    wait_drained();
    send_frame(rows_in_use(), 32);
  endtask

  // random sizes and words under one idling setting
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start;
    int unsigned n_items;
    logic [6:0]  r_raw;
    logic [6:0]  c_raw;
    set_idling(send_pct, recv_pct);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        6: begin
          r_raw = 7'($urandom_range(17, 64));
          c_raw = 7'($urandom_range(1, 2));
        end
        7: begin
          r_raw = 7'($urandom_range(1, 3));
          c_raw = 7'($urandom_range(9, 63));
        end
        8: begin
          r_raw = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
          c_raw = 7'($urandom_range(0, 2));
        end
        9: begin
          r_raw = 7'($urandom_range(9, 16));
          c_raw = 7'($urandom_range(1, 3));
        end
        default: begin
          r_raw = 7'($urandom_range(1, 8));
          c_raw = 7'($urandom_range(1, 4));
        end
      endcase
      // bit six of the col_count word is dropped
      if ($urandom_range(0, 3) == 0) c_raw[6] = 1'b1;
      write_reg(REG_ROW_COUNT, r_raw);
      write_reg(REG_COL_COUNT, c_raw);
      n_items = rows_in_use() * cols_in_use();
      if (n_items <= 64) n_items = n_items * $urandom_range(1, 3);
      // some frames are cut short by the next register write
      if ($urandom_range(0, 5) == 0) n_items = $urandom_range(1, n_items);
      send_frame(rows_in_use(), n_items);
    end
  endtask

  // stimulus
  initial begin
    rst_n          = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.word  = '0;
    res_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_ROW_COUNT;
    cfg_bus.data   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_single_column();
    test_saturation();
    test_count_clamping();
    test_unmapped_write();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(87, 0);
    test_random_phase(0, 87);
    test_random_phase(38, 38);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_rows.size() == 0) begin
      $display("complex_int16_matvec_unit: match");
    end else begin
      $display("complex_int16_matvec_unit: mismatch");
    end
    $finish;
  end

endmodule
